### sv/klex_pkg.sv
// Package for kth_lexicographic_number: widths, microcode word format and the program ROM.
package klex_pkg;

   localparam int VALUE_BITS = 30;
   localparam int WIDE_BITS  = VALUE_BITS + 4;
   localparam int RADIX      = 10;

   localparam int STEP_COUNT = 5;
   localparam int STEP_BITS  = $clog2(STEP_COUNT);

   localparam logic [STEP_BITS-1:0] STEP_WAIT = STEP_BITS'(0);
   localparam logic [STEP_BITS-1:0] STEP_TEST = STEP_BITS'(1);
   localparam logic [STEP_BITS-1:0] STEP_SACC = STEP_BITS'(2);
   localparam logic [STEP_BITS-1:0] STEP_MOVE = STEP_BITS'(3);
   localparam logic [STEP_BITS-1:0] STEP_EMIT = STEP_BITS'(4);

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_ACC,
      OP_MOVE,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_STOP,
      COND_IN_RANGE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type                 op;
      cond_type               cond;
      logic [STEP_BITS-1:0]   target;
   } ctrl_word_type;

   // jump to target when cond holds, else fall through to the next step
   function automatic ctrl_word_type klex_rom(input logic [STEP_BITS-1:0] step);
      ctrl_word_type w;
      unique case (step)
         STEP_WAIT: w = '{op: OP_LOAD, cond: COND_NO_REQ,   target: STEP_WAIT};
         STEP_TEST: w = '{op: OP_NOP,  cond: COND_STOP,     target: STEP_EMIT};
         STEP_SACC: w = '{op: OP_ACC,  cond: COND_IN_RANGE, target: STEP_SACC};
         STEP_MOVE: w = '{op: OP_MOVE, cond: COND_ALWAYS,   target: STEP_TEST};
         STEP_EMIT: w = '{op: OP_EMIT, cond: COND_OUT_BUSY, target: STEP_EMIT};
         default:   w = '{op: OP_NOP,  cond: COND_ALWAYS,   target: STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

### sv/kth_lexicographic_number.sv
// Top level: k-th smallest of 1..n in decimal string order, microcoded sequencer.
//
// Usage: present limit n and rank k on req_limit/req_rank with req_valid; the
// word is taken when req_valid is high and req_stall is low. One result word
// (rsp_answer, rsp_invalid) follows on the rsp_ channel for every request.
// A rank of zero or above the limit gives rsp_invalid = 1 and answer 0.
// One request is worked on at a time. A five-step microprogram walks the
// decimal prefix tree: per visited node it counts the node's subtree one
// decimal level per cycle, then skips the subtree or descends into it.
// The walk visits at most 10 levels and 10 nodes per level. Invalid requests
// go from the test step straight to the emit step. One idle step follows each
// result before the wait step, so a new request is taken only after the
// previous result has been emitted and that idle step has passed.
// The result sits in an output register; a new request is taken while it
// waits. A held rsp_stall keeps the result stable and, once the next result
// is ready, holds the sequencer on its final step.
// Reset (synchronous, active high) returns the sequencer to its wait step and
// drops rsp_valid; no clearing pass is needed.
module kth_lexicographic_number (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [klex_pkg::VALUE_BITS-1:0]  req_limit,
   input  logic [klex_pkg::VALUE_BITS-1:0]  req_rank,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [klex_pkg::VALUE_BITS-1:0]  rsp_answer,
   output logic                             rsp_invalid
);

   localparam int W  = klex_pkg::VALUE_BITS;
   localparam int WW = klex_pkg::WIDE_BITS;

   logic [klex_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic [W-1:0]  limit_ff, limit_in;
   logic [W-1:0]  node_ff, node_in;
   logic [W-1:0]  left_ff, left_in;
   logic [WW-1:0] first_ff, first_in;
   logic [W-1:0]  last_ff, last_in;
   logic [W-1:0]  total_ff, total_in;
   logic          invalid_ff, invalid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]  rsp_answer_ff, rsp_answer_in;
   logic          rsp_invalid_ff, rsp_invalid_in;

   klex_pkg::ctrl_word_type ctrl;
   logic          in_range;
   logic          out_busy;
   logic          cond_true;
   logic [W-1:0]  first_low;
   logic [WW-1:0] first_x10;
   logic [WW-1:0] last_x10p9;
   logic [W-1:0]  node_x10;
   logic [W-1:0]  count;
   logic          skip;
   logic [W-1:0]  node_nx;

   assign req_stall   = (step_ff != klex_pkg::STEP_WAIT);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_answer  = rsp_answer_ff;
   assign rsp_invalid = rsp_invalid_ff;

   always_comb begin
      ctrl       = klex_pkg::klex_rom(step_ff);
      in_range   = (first_ff <= WW'(limit_ff));
      out_busy   = rsp_valid_ff && rsp_stall;
      first_low  = first_ff[W-1:0];
      first_x10  = (WW'(first_low) << 3) + (WW'(first_low) << 1);
      last_x10p9 = (WW'(last_ff) << 3) + (WW'(last_ff) << 1) + WW'(klex_pkg::RADIX - 1);
      node_x10   = (node_ff << 3) + (node_ff << 1);
      count      = last_ff - first_low + W'(1);
      skip       = (total_ff <= left_ff);
      node_nx    = skip ? node_ff + W'(1) : node_x10;

      unique case (ctrl.cond)
         klex_pkg::COND_NEVER:    cond_true = 1'b0;
         klex_pkg::COND_ALWAYS:   cond_true = 1'b1;
         klex_pkg::COND_NO_REQ:   cond_true = !req_valid;
         klex_pkg::COND_STOP:     cond_true = invalid_ff || (left_ff == '0);
         klex_pkg::COND_IN_RANGE: cond_true = in_range;
         klex_pkg::COND_OUT_BUSY: cond_true = out_busy;
         default:                 cond_true = 1'b1;
      endcase

      step_in = cond_true ? ctrl.target : step_ff + klex_pkg::STEP_BITS'(1);

      limit_in       = limit_ff;
      node_in        = node_ff;
      left_in        = left_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      total_in       = total_ff;
      invalid_in     = invalid_ff;
      rsp_answer_in  = rsp_answer_ff;
      rsp_invalid_in = rsp_invalid_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      unique case (ctrl.op)
         klex_pkg::OP_NOP: begin
         end
         klex_pkg::OP_LOAD: begin
            if (req_valid) begin
               limit_in   = req_limit;
               invalid_in = (req_rank == '0) || (req_rank > req_limit);
               node_in    = W'(1);
               left_in    = req_rank - W'(1);
               first_in   = WW'(1);
               last_in    = W'(1);
               total_in   = '0;
            end
         end
         klex_pkg::OP_ACC: begin
            if (in_range) begin
               total_in = total_ff + count;
               first_in = first_x10;
               last_in  = (last_x10p9 > WW'(limit_ff)) ? limit_ff : last_x10p9[W-1:0];
            end
         end
         klex_pkg::OP_MOVE: begin
            left_in  = skip ? left_ff - total_ff : left_ff - W'(1);
            node_in  = node_nx;
            first_in = WW'(node_nx);
            last_in  = node_nx;
            total_in = '0;
         end
         klex_pkg::OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in   = 1'b1;
               rsp_answer_in  = invalid_ff ? '0 : node_ff;
               rsp_invalid_in = invalid_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= klex_pkg::STEP_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      limit_ff       <= limit_in;
      node_ff        <= node_in;
      left_ff        <= left_in;
      first_ff       <= first_in;
      last_ff        <= last_in;
      total_ff       <= total_in;
      invalid_ff     <= invalid_in;
      rsp_answer_ff  <= rsp_answer_in;
      rsp_invalid_ff <= rsp_invalid_in;
   end

`ifndef SYNTHESIS
   a_accept_to_test: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> step_ff == klex_pkg::STEP_TEST)
      else $error("accepted word did not start the program");

   a_last_bounded: assert property (@(posedge clock) disable iff (reset)
      (step_ff == klex_pkg::STEP_SACC || step_ff == klex_pkg::STEP_MOVE) && !invalid_ff
      |-> last_ff <= limit_ff)
      else $error("subtree upper bound above limit");

   a_subtree_nonempty: assert property (@(posedge clock) disable iff (reset)
      step_ff == klex_pkg::STEP_MOVE && !invalid_ff |-> total_ff != '0)
      else $error("visited node has empty subtree");
`endif

endmodule

### bench/testbench.sv
// Testbench for kth_lexicographic_number: directed and random requests checked against a predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [klex_pkg::VALUE_BITS-1:0] value_type;

   typedef struct {
      value_type answer;
      logic      invalid;
   } lex_result_type;

   localparam value_type MAXV = '1;
   localparam longint unsigned BASE = klex_pkg::RADIX;
   localparam int RANDOM_WORDS = 850;
   localparam int HOLD_CYCLES = 5000;
   localparam int DRAIN_CYCLES = 1200;
   localparam int CYCLE_LIMIT = 3000000;

   class lex_scoreboard;
      lex_result_type due[$];
      int errors;
      int checked;

      // integers in 1..n that carry 'node' as a decimal prefix
      function longint unsigned prefix_count(longint unsigned node, longint unsigned n);
         longint unsigned lo, hi, top, total;
         lo = node;
         hi = node;
         total = 0;
         while (lo <= n) begin
            top = (hi < n) ? hi : n;
            total += top - lo + 1;
            lo = lo * BASE;
            hi = hi * BASE + (BASE - 1);
         end
         return total;
      endfunction

      function lex_result_type kth_in_order(value_type lim, value_type rnk);
         lex_result_type r;
         longint unsigned n, k, node, left, span;
         n = lim;
         k = rnk;
         r.answer = '0;
         r.invalid = 1'b1;
         if (k == 0 || k > n) return r;
         node = 1;
         left = k - 1;
         while (left > 0) begin
            span = prefix_count(node, n);
            if (span <= left) begin
               left -= span;
               node += 1;
            end else begin
               left -= 1;
               node = node * BASE;
            end
         end
         r.answer = value_type'(node);
         r.invalid = 1'b0;
         return r;
      endfunction

      function void note_request(value_type lim, value_type rnk);
         due.push_back(kth_in_order(lim, rnk));
      endfunction

      function void check_result(value_type ans, logic inv);
         lex_result_type want;
         checked++;
         if (due.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, answer %0d invalid %0b", $time, ans, inv);
            return;
         end
         want = due.pop_front();
         if (ans !== want.answer) begin
            errors++;
            $display("%0t: answer mismatch, expected %0d, actual %0d",
                     $time, want.answer, ans);
         end
         if (inv !== want.invalid) begin
            errors++;
            $display("%0t: invalid mismatch, expected %0b, actual %0b",
                     $time, want.invalid, inv);
         end
      endfunction

      function int pending();
         return due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   value_type req_limit;
   value_type req_rank;
   logic rsp_valid;
   logic rsp_stall;
   value_type rsp_answer;
   logic rsp_invalid;

   bit calm;
   int cycles;
   lex_scoreboard sb = new;

   kth_lexicographic_number u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_limit(req_limit),
      .req_rank(req_rank),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_answer(rsp_answer),
      .rsp_invalid(rsp_invalid)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_word(input value_type lim, input value_type rnk);
      while (!calm && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_limit <= lim;
      req_rank  <= rnk;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(lim, rnk);
      @(negedge clock);
   endtask

   // result side: random stalls plus one long hold-off to back the block up
   initial begin
      int hold;
      bit held;
      hold = 0;
      held = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && sb.checked >= 60) begin
            held = 1;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 30);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_answer, rsp_invalid);
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      value_type lim, rnk;
      int unsigned p;
      int pick;
      reset = 1'b1;
      req_valid = 1'b0;
      req_limit = '0;
      req_rank = '0;
      calm = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: range edges, invalid ranks, small worked example, powers of ten
      send_word(1, 1);
      send_word(1, 0);
      send_word(1, 2);
      send_word(0, 0);
      send_word(0, 1);
      send_word(13, 1);
      send_word(13, 2);
      send_word(13, 5);
      send_word(13, 6);
      send_word(13, 13);
      send_word(13, 14);
      send_word(10, 2);
      send_word(100, 100);
      send_word(99, 99);
      send_word(MAXV, 1);
      send_word(MAXV, 0);
      send_word(MAXV, MAXV);
      send_word(MAXV - 1, MAXV);
      send_word(MAXV, 30'h2000_0000);
      send_word(30'd1000000000, 30'd1000000000);
      send_word(30'd1000000000, 2);
      send_word(30'd1000000001, 30'd999999999);
      send_word(30'h1555_5555, 30'h0AAA_AAAA);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         calm = (i >= 400 && i < 520);
         pick = $urandom_range(99);
         if (pick < 30) begin
            lim = value_type'($urandom_range(200, 1));
         end else if (pick < 55) begin
            lim = value_type'($urandom_range(100000, 1));
         end else if (pick < 85) begin
            lim = value_type'($urandom);
         end else begin
            p = 1;
            repeat ($urandom_range(9)) p = p * 10;
            lim = value_type'(p + $urandom_range(2) - 1);
         end
         pick = $urandom_range(99);
         if (pick < 8) begin
            rnk = '0;
         end else if (pick < 14) begin
            if (lim != MAXV) rnk = value_type'($urandom_range(MAXV, lim + 1));
            else rnk = '0;
         end else if (pick < 20) begin
            rnk = ($urandom_range(1) != 0) ? lim : value_type'(1);
         end else if (lim != '0) begin
            rnk = value_type'($urandom_range(lim, 1));
         end else begin
            rnk = value_type'($urandom);
         end
         send_word(lim, rnk);
      end
      calm = 0;
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
